// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL files that check their own logic.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define AMDFS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a trigger in one cycle implies a condition in the same cycle.
`define AMDFS_IMPLY(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle.
`define AMDFS_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- hdl/amdfs_pkg.sv -----
package amdfs_pkg;

  localparam int VERTICES = 16;
  localparam int VW       = $clog2(VERTICES);
  localparam int NW       = $clog2(VERTICES + 1);
  localparam int DW       = $clog2(VERTICES + 1);

  typedef logic [VERTICES-1:0] row_t;

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [NW-1:0] next;
  } stack_entry_t;

  typedef struct packed {
    logic          found;
    logic [VW-1:0] idx;
  } scan_res_t;

  localparam int STACK_W = $bits(stack_entry_t);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_VERTEX = 2'd2;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_SELF_LOOP = 1'b1;

endpackage

// ----- hdl/amdfs_ram.sv -----
module amdfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/amdfs_scan.sv -----
module amdfs_scan
  import amdfs_pkg::*;
(
  input  row_t            row,
  input  row_t            visited,
  input  logic [NW-1:0]   start_idx,
  output scan_res_t       res
);

  row_t cand;

  // Lowest unvisited neighbor at or above the resume index.
  always_comb begin
    for (int c = 0; c < VERTICES; c++) begin
      cand[c] = row[c] & ~visited[c] & (NW'(c) >= start_idx);
    end
    res.found = |cand;
    res.idx   = '0;
    for (int c = VERTICES - 1; c >= 0; c--) begin
      if (cand[c]) begin
        res.idx = VW'(c);
      end
    end
  end

endmodule

// ----- hdl/adjacency_matrix_graph_dfs.sv -----
// Graph engine over a 16-vertex bit matrix of edges held in a one-port-read synchronous
// memory, with the depth-first walk stack in a second memory. After reset busy stays high
// while the matrix is swept to zero. Start is taken when busy is low; each result word
// is on the out_ ports for exactly one cycle under out_strobe and cannot be held off.
// An insert writes the source row back with the edge set, and the destination row too
// when undirected_r mirrors the edge; a self loop answers without leaving idle; a clear
// is taken, then sweeps all 16 matrix rows to zero; a search passes S_SCAN for each
// visited vertex and S_POP then S_SCAN per backtrack step, each step waiting on the read
// of an edge row or stack entry. The last word of every item has out_last_of_run set;
// opcode 3 is taken and gives no result. Write cfg_wr_data only while busy is low.
`include "assert_macros.svh"

module adjacency_matrix_graph_dfs
  import amdfs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_opcode,
  input  logic [3:0]    in_from_vertex,
  input  logic [3:0]    in_to_vertex,
  input  logic [3:0]    in_start_vertex,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  output logic          out_strobe,
  output logic [1:0]    out_result_kind,
  output logic [3:0]    out_vertex,
  output logic          out_status,
  output logic          out_last_of_run
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_FROM = 3'd1;
  localparam logic [2:0] S_INS_TO   = 3'd2;
  localparam logic [2:0] S_CLR      = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_POP      = 3'd5;
  localparam logic [2:0] S_INIT     = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [VW-1:0] from_r, from_nxt;
  logic [VW-1:0] to_r, to_nxt;
  logic [VW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [VW-1:0] cur_v_r, cur_v_nxt;
  logic [NW-1:0] cur_next_r, cur_next_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  row_t          visited_r, visited_nxt;
  logic [VW-1:0] pend_v_r, pend_v_nxt;
  logic          undirected_r;

  logic          out_strobe_r, out_strobe_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [VW-1:0] out_vertex_r, out_vertex_nxt;
  logic          out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  logic          e_we;
  logic [VW-1:0] e_waddr;
  row_t          e_wdata;
  logic [VW-1:0] e_raddr;
  row_t          e_rdata;

  logic          s_we;
  stack_entry_t  s_wdata;
  stack_entry_t  s_rdata;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] depth_m2;

  scan_res_t     scan;
  logic          accept;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);

  amdfs_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  amdfs_ram #(.WIDTH(STACK_W), .DEPTH(VERTICES)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (depth_m1[VW-1:0]),
    .wdata (s_wdata),
    .raddr (depth_m2[VW-1:0]),
    .rdata (s_rdata)
  );

  amdfs_scan u_scan (
    .row       (e_rdata),
    .visited   (visited_r),
    .start_idx (cur_next_r),
    .res       (scan)
  );

  always_comb begin
    state_nxt      = state_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_v_nxt      = cur_v_r;
    cur_next_nxt   = cur_next_r;
    depth_nxt      = depth_r;
    visited_nxt    = visited_r;
    pend_v_nxt     = pend_v_r;
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_vertex_nxt = out_vertex_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    e_we           = 1'b0;
    e_waddr        = from_r;
    e_wdata        = e_rdata;
    e_raddr        = cur_v_r;
    s_we           = 1'b0;
    s_wdata.vtx    = cur_v_r;
    s_wdata.next   = {1'b0, scan.idx} + NW'(1);

    case (state_r)
      S_IDLE: begin
        e_raddr = (in_opcode == OP_INSERT) ? in_from_vertex : in_start_vertex;
        if (accept) begin
          case (in_opcode)
            OP_INSERT: begin
              from_nxt = in_from_vertex;
              to_nxt   = in_to_vertex;
              if (in_from_vertex == in_to_vertex) begin
                out_strobe_nxt = 1'b1;
                out_kind_nxt   = KIND_INSERT;
                out_vertex_nxt = '0;
                out_status_nxt = ST_SELF_LOOP;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = S_INS_FROM;
              end
            end
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
            OP_SEARCH: begin
              visited_nxt  = row_t'(1) << in_start_vertex;
              cur_v_nxt    = in_start_vertex;
              cur_next_nxt = '0;
              depth_nxt    = DW'(1);
              pend_v_nxt   = in_start_vertex;
              state_nxt    = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_INIT: begin
        // sweep the matrix to zero after reset, no word
        e_we        = 1'b1;
        e_waddr     = clr_cnt_r;
        e_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + VW'(1);
        if (clr_cnt_r == VW'(VERTICES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_INS_FROM: begin
        e_we    = 1'b1;
        e_waddr = from_r;
        e_wdata = e_rdata | (row_t'(1) << to_r);
        e_raddr = to_r;
        if (undirected_r) begin
          state_nxt = S_INS_TO;
        end else begin
          out_strobe_nxt = 1'b1;
          out_kind_nxt   = KIND_INSERT;
          out_vertex_nxt = '0;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_INS_TO: begin
        e_we           = 1'b1;
        e_waddr        = to_r;
        e_wdata        = e_rdata | (row_t'(1) << from_r);
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_INSERT;
        out_vertex_nxt = '0;
        out_status_nxt = ST_OK;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_CLR: begin
        e_we        = 1'b1;
        e_waddr     = clr_cnt_r;
        e_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + VW'(1);
        if (clr_cnt_r == VW'(VERTICES - 1)) begin
          out_strobe_nxt = 1'b1;
          out_kind_nxt   = KIND_CLEAR;
          out_vertex_nxt = '0;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_SCAN: begin
        if (scan.found) begin
          // save the resume point of this frame, descend into the neighbor
          s_we           = 1'b1;
          out_strobe_nxt = 1'b1;
          out_kind_nxt   = KIND_VERTEX;
          out_vertex_nxt = pend_v_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b0;
          pend_v_nxt     = scan.idx;
          visited_nxt    = visited_r | (row_t'(1) << scan.idx);
          cur_v_nxt      = scan.idx;
          cur_next_nxt   = '0;
          depth_nxt      = depth_r + DW'(1);
          e_raddr        = scan.idx;
        end else if (depth_r == DW'(1)) begin
          // walk done: the held word is the last one
          out_strobe_nxt = 1'b1;
          out_kind_nxt   = KIND_VERTEX;
          out_vertex_nxt = pend_v_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          visited_nxt    = '0;
          depth_nxt      = '0;
          state_nxt      = S_IDLE;
        end else begin
          depth_nxt = depth_m1;
          state_nxt = S_POP;
        end
      end

      S_POP: begin
        cur_v_nxt    = s_rdata.vtx;
        cur_next_nxt = s_rdata.next;
        e_raddr      = s_rdata.vtx;
        state_nxt    = S_SCAN;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      clr_cnt_r    <= '0;
      depth_r      <= '0;
      visited_r    <= '0;
      out_strobe_r <= 1'b0;
      undirected_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      depth_r      <= depth_nxt;
      visited_r    <= visited_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        undirected_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    cur_v_r      <= cur_v_nxt;
    cur_next_r   <= cur_next_nxt;
    pend_v_r     <= pend_v_nxt;
    out_kind_r   <= out_kind_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_result_kind = out_kind_r;
  assign out_vertex      = out_vertex_r;
  assign out_status      = out_status_r;
  assign out_last_of_run = out_last_r;

  `AMDFS_IMPLY(a_idle_clean, state_r == S_IDLE, depth_r == '0 && visited_r == '0, "dirty idle")
  `AMDFS_IMPLY(a_scan_depth, state_r == S_SCAN || state_r == S_POP, depth_r != '0, "empty stack")
  `AMDFS_NEXT(a_search_start, accept && in_opcode == OP_SEARCH, state_r == S_SCAN, "no search")
  `AMDFS_IMPLY(a_last_idle, out_strobe_r && out_last_r, state_r == S_IDLE, "last word while busy")

endmodule

// ----- tb/adjacency_matrix_graph_dfs_tb.sv -----
`timescale 1ns / 100ps

module adjacency_matrix_graph_dfs_tb
  import amdfs_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] vertex;
    logic       status;
    logic       last;
  } result_word_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_opcode;
  logic [3:0] in_from_vertex;
  logic [3:0] in_to_vertex;
  logic [3:0] in_start_vertex;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       out_strobe;
  logic [1:0] out_result_kind;
  logic [3:0] out_vertex;
  logic       out_status;
  logic       out_last_of_run;

  // Model of the graph state
  row_t edge_model [VERTICES];
  logic mirror_mode;

  result_word_t pending_words[$];
  result_word_t exp_word;
  int           errors;
  int           sender_idle_pct;
  int           idle_cycles;

  adjacency_matrix_graph_dfs u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_from_vertex (in_from_vertex),
    .in_to_vertex   (in_to_vertex),
    .in_start_vertex(in_start_vertex),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_result_kind(out_result_kind),
    .out_vertex     (out_vertex),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the words caused by one accepted item and update the model
  function automatic void predict_graph_op(input logic [1:0] op, input logic [3:0] src,
                                           input logic [3:0] dst, input logic [3:0] root);
    result_word_t words [VERTICES];
    logic [3:0]   stk_vtx [VERTICES];
    logic [4:0]   stk_next [VERTICES];
    row_t         visited;
    logic [3:0]   cur;
    int           n;
    int           depth;
    int           top;
    int           c;
    bit           pushed;
    n = 0;
    case (op)
      OP_INSERT: begin
        words[0] = '{KIND_INSERT, 4'd0, ST_OK, 1'b1};
        if (src == dst) begin
          words[0].status = ST_SELF_LOOP;
        end else begin
          edge_model[src][dst] = 1'b1;
          if (mirror_mode) edge_model[dst][src] = 1'b1;
        end
        n = 1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < VERTICES; i++) edge_model[i] = '0;
        words[0] = '{KIND_CLEAR, 4'd0, ST_OK, 1'b1};
        n = 1;
      end
      OP_SEARCH: begin
        visited = '0;
        visited[root] = 1'b1;
        stk_vtx[0] = root;
        stk_next[0] = '0;
        depth = 1;
        words[0] = '{KIND_VERTEX, root, ST_OK, 1'b0};
        n = 1;
        while (depth > 0) begin
          top = depth - 1;
          cur = stk_vtx[top];
          c = int'(stk_next[top]);
          pushed = 1'b0;
          while (c < VERTICES && !pushed) begin
            if (!visited[c[3:0]] && edge_model[cur][c[3:0]]) begin
              // descend into the first unvisited neighbor, resume after it later
              stk_next[top] = 5'(c + 1);
              visited[c[3:0]] = 1'b1;
              stk_vtx[depth] = c[3:0];
              stk_next[depth] = '0;
              depth++;
              words[n] = '{KIND_VERTEX, c[3:0], ST_OK, 1'b0};
              n++;
              pushed = 1'b1;
            end else begin
              c++;
            end
          end
          if (!pushed) depth--;
        end
        words[n-1].last = 1'b1;
      end
      default: n = 0;
    endcase
    for (int i = 0; i < n; i++) pending_words.push_back(words[i]);
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d vertex=%0d status=%0d last=%0d", $time,
                 out_result_kind, out_vertex, out_status, out_last_of_run);
        errors++;
      end else begin
        exp_word = pending_words.pop_front();
        if (out_result_kind !== exp_word.kind || out_vertex !== exp_word.vertex ||
            out_status !== exp_word.status || out_last_of_run !== exp_word.last) begin
          $display("%0t: mismatch expected k=%0d v=%0d s=%0d l=%0d actual k=%0d v=%0d s=%0d l=%0d",
                   $time, exp_word.kind, exp_word.vertex, exp_word.status, exp_word.last,
                   out_result_kind, out_vertex, out_status, out_last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_graph_op(input logic [1:0] op, input logic [3:0] src,
                               input logic [3:0] dst, input logic [3:0] root);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start           <= 1'b0;
      in_opcode       <= 2'($urandom);
      in_from_vertex  <= 4'($urandom);
      in_to_vertex    <= 4'($urandom);
      in_start_vertex <= 4'($urandom);
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_from_vertex  <= src;
    in_to_vertex    <= dst;
    in_start_vertex <= root;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_graph_op(op, src, dst, root);
  endtask

  // Drop start, let every expected word arrive, then hold off for the tail of
  // an item that gives no result
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_mirror_mode(input logic mode);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    mirror_mode = mode;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= ~mode;
  endtask

  task automatic test_insert_extremes();
    send_graph_op(OP_INSERT, 4'd0, 4'd15, 4'd15);
    send_graph_op(OP_INSERT, 4'd15, 4'd0, 4'd0);
    send_graph_op(OP_INSERT, 4'd1, 4'd14, 4'd9);
    send_graph_op(OP_INSERT, 4'd14, 4'd7, 4'd6);
  endtask

  task automatic test_self_loop();
    send_graph_op(OP_INSERT, 4'd0, 4'd0, 4'd3);
    send_graph_op(OP_INSERT, 4'd15, 4'd15, 4'd12);
    send_graph_op(OP_INSERT, 4'd9, 4'd9, 4'd9);
  endtask

  task automatic test_search_roots();
    send_graph_op(OP_SEARCH, 4'd3, 4'd5, 4'd0);
    send_graph_op(OP_SEARCH, 4'd15, 4'd0, 4'd15);
    send_graph_op(OP_SEARCH, 4'd0, 4'd0, 4'd11);
    send_graph_op(OP_SEARCH, 4'd10, 4'd10, 4'd7);
  endtask

  task automatic test_unused_opcode();
    send_graph_op(OP_UNUSED, 4'd2, 4'd3, 4'd0);
    send_graph_op(OP_UNUSED, 4'd15, 4'd15, 4'd15);
    send_graph_op(OP_SEARCH, 4'd0, 4'd0, 4'd1);
  endtask

  task automatic test_directed_edges();
    write_mirror_mode(1'b0);
    send_graph_op(OP_CLEAR, 4'd0, 4'd0, 4'd0);
    send_graph_op(OP_INSERT, 4'd3, 4'd4, 4'd0);
    send_graph_op(OP_INSERT, 4'd4, 4'd5, 4'd0);
    send_graph_op(OP_INSERT, 4'd5, 4'd3, 4'd0);
    send_graph_op(OP_SEARCH, 4'd0, 4'd0, 4'd5);
    send_graph_op(OP_SEARCH, 4'd0, 4'd0, 4'd4);
    send_graph_op(OP_SEARCH, 4'd0, 4'd0, 4'd6);
    write_mirror_mode(1'b1);
  endtask

  task automatic test_clear_matrix();
    send_graph_op(OP_CLEAR, 4'd15, 4'd15, 4'd15);
    send_graph_op(OP_SEARCH, 4'd0, 4'd0, 4'd0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input logic mode, input int count);
    int         sent;
    int         pick;
    logic [3:0] a;
    logic [3:0] b;
    sender_idle_pct = idle_pct;
    write_mirror_mode(mode);
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      a = 4'($urandom);
      b = a + 4'($urandom_range(1, 15));
      if (pick < 4) begin
        send_graph_op(OP_UNUSED, 4'($urandom), 4'($urandom), 4'($urandom));
      end else begin
        if (pick < 8) send_graph_op(OP_CLEAR, 4'($urandom), 4'($urandom), 4'($urandom));
        else if (pick < 13) send_graph_op(OP_INSERT, a, a, 4'($urandom));
        else if (pick < 60) send_graph_op(OP_INSERT, a, b, 4'($urandom));
        else send_graph_op(OP_SEARCH, 4'($urandom), 4'($urandom), a);
        sent++;
      end
    end
  endtask

  initial begin
    errors = 0;
    sender_idle_pct = 0;
    mirror_mode = 1'b1;
    for (int i = 0; i < VERTICES; i++) edge_model[i] = '0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= '0;
    in_from_vertex  <= '0;
    in_to_vertex    <= '0;
    in_start_vertex <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_insert_extremes();
    test_self_loop();
    test_search_roots();
    test_unused_opcode();
    test_directed_edges();
    test_clear_matrix();
    test_random_traffic(27, 1'b1, 130);
    test_random_traffic(59, 1'b0, 120);
    test_random_traffic(0, 1'b1, 120);

    wait_drained();
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
